// ===== rtl/som_bmu_pkg.sv =====
// ----------------------------------------------------------------------------
// som_bmu_pkg
// Shared types, constants and the influence table of the map trainer.
// ----------------------------------------------------------------------------
package som_bmu_pkg;

   localparam int MAX_COLUMNS_DEF = 16;
   localparam int MAX_ROWS_DEF    = 16;
   localparam int MAX_DIM_DEF     = 16;

   // grid coordinates up to 64, distance sums up to 64 terms of 32 bits
   localparam int CRD_W = 6;
   localparam int SUM_W = 39;
   localparam int CFG_W = 5;

   localparam logic [1:0] FUNC_WRITE = 2'd0;
   localparam logic [1:0] FUNC_READ  = 2'd1;
   localparam logic [1:0] FUNC_TRAIN = 2'd2;
   localparam logic [1:0] FUNC_NONE  = 2'd3;

   localparam logic [1:0] REG_MAP_WIDTH     = 2'd0;
   localparam logic [1:0] REG_MAP_HEIGHT    = 2'd1;
   localparam logic [1:0] REG_VECTOR_LENGTH = 2'd2;

   localparam logic [15:0] INFL_TABLE [32] = '{
      16'd65535, 16'd64520, 16'd63520, 16'd62535, 16'd61565, 16'd60611, 16'd59671, 16'd58746,
      16'd57835, 16'd56939, 16'd56056, 16'd55187, 16'd54331, 16'd53489, 16'd52660, 16'd51843,
      16'd51039, 16'd50248, 16'd49469, 16'd48702, 16'd47947, 16'd47204, 16'd46472, 16'd45752,
      16'd45043, 16'd44344, 16'd43657, 16'd42980, 16'd42314, 16'd41658, 16'd41012, 16'd40376
   };

   typedef struct packed {
      logic [1:0]         func;
      logic [7:0]         node_index;
      logic [3:0]         dim_index;
      logic signed [15:0] value;
      logic [15:0]        gain;
      logic [23:0]        neighborhood_sq;
      logic               last_element;
   } req_type;

   typedef struct packed {
      logic signed [15:0] read_value;
      logic [3:0]         winner_column;
      logic [3:0]         winner_row;
      logic [35:0]        winner_distance_sq;
   } rsp_type;

   // one node moving along the cell row
   typedef struct packed {
      logic             valid;
      logic             train;
      logic [CRD_W-1:0] row;
      logic [CRD_W-1:0] col;
      logic [15:0]      infl;
      logic [SUM_W-1:0] sum;
   } link_type;

   // host weight and sample access, broadcast to all cells
   typedef struct packed {
      logic               rd;
      logic               wr;
      logic               sample;
      logic [3:0]         dim;
      logic [3:0]         row;
      logic [3:0]         col;
      logic signed [15:0] value;
   } host_type;

endpackage

// ===== rtl/som_bmu_ram.sv =====
// ----------------------------------------------------------------------------
// som_bmu_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module som_bmu_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/som_bmu_cell.sv =====
// ----------------------------------------------------------------------------
// som_bmu_cell
// One vector element: sample element, weight column of all nodes, and a
// three-stage slot that adds its squared difference or updates its weight.
// ----------------------------------------------------------------------------
module som_bmu_cell #(
   parameter int MAX_ROWS    = som_bmu_pkg::MAX_ROWS_DEF,
   parameter int MAX_COLUMNS = som_bmu_pkg::MAX_COLUMNS_DEF,
   parameter int IDX         = 0
) (
   input  logic                  clock,
   input  logic                  reset,
   input  som_bmu_pkg::link_type link_in,
   input  som_bmu_pkg::host_type host,
   input  logic                  active,
   input  logic [15:0]           gain,
   output som_bmu_pkg::link_type link_out,
   output logic signed [15:0]    rd_value
);

   localparam int NODES = MAX_ROWS * MAX_COLUMNS;
   localparam int AW    = (NODES > 1) ? $clog2(NODES) : 1;

   logic                  sel;
   logic signed [15:0]    sample_ff;
   logic [AW-1:0]         host_addr;
   logic [AW-1:0]         link_addr;
   logic [AW-1:0]         wb_addr;
   logic                  rd_en;
   logic [AW-1:0]         rd_addr;
   logic                  we;
   logic [AW-1:0]         wa;
   logic [15:0]           wd;
   logic [15:0]           ram_q;
   logic signed [15:0]    w;
   som_bmu_pkg::link_type s1_ff;
   som_bmu_pkg::link_type s2_ff;
   som_bmu_pkg::link_type s3_ff;
   som_bmu_pkg::link_type s3_in;
   logic signed [16:0]    diff;
   logic signed [16:0]    mul_b;
   logic signed [33:0]    prod;
   logic signed [33:0]    s2_prod_ff;
   logic signed [15:0]    s2_w_ff;
   logic signed [50:0]    p_in;
   logic signed [50:0]    s3_p_ff;
   logic signed [15:0]    s3_w_ff;
   logic signed [18:0]    shifted;
   logic signed [19:0]    nw;
   logic signed [15:0]    sat_w;
   logic                  upd_we;

   assign sel       = (int'(host.dim) == IDX);
   assign host_addr = AW'(int'(host.row) * MAX_COLUMNS + int'(host.col));
   assign link_addr = AW'(int'(link_in.row) * MAX_COLUMNS + int'(link_in.col));
   assign wb_addr   = AW'(int'(s3_ff.row) * MAX_COLUMNS + int'(s3_ff.col));

   always_ff @(posedge clock) begin
      if (host.sample && sel) begin
         sample_ff <= host.value;
      end
   end

   assign rd_en   = (host.rd && sel) || link_in.valid;
   assign rd_addr = link_in.valid ? link_addr : host_addr;
   assign upd_we  = s3_ff.valid && s3_ff.train && active;
   assign we      = (host.wr && sel) || upd_we;
   assign wa      = upd_we ? wb_addr : host_addr;
   assign wd      = upd_we ? sat_w : host.value;

   som_bmu_ram #(
      .WIDTH(16),
      .DEPTH(NODES)
   ) u_ram (
      .clock  (clock),
      .wr_en  (we),
      .wr_addr(wa),
      .wr_data(wd),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(ram_q)
   );

   assign w        = signed'(ram_q);
   assign rd_value = w;

   // stage 2: square of the difference, or difference times gain
   assign diff  = {sample_ff[15], sample_ff} - {w[15], w};
   assign mul_b = s1_ff.train ? signed'({1'b0, gain}) : diff;
   assign prod  = diff * mul_b;

   // stage 3: accumulate, or scale by the influence
   assign p_in = s2_prod_ff * signed'({1'b0, s2_ff.infl});

   always_comb begin
      s3_in = s2_ff;
      if (!s2_ff.train && active) begin
         s3_in.sum = s2_ff.sum + som_bmu_pkg::SUM_W'(s2_prod_ff[32:0]);
      end
   end

   assign shifted = s3_p_ff[50:32];
   assign nw      = {{4{s3_w_ff[15]}}, s3_w_ff} + {shifted[18], shifted};

   always_comb begin
      if (nw > 20'sd32767) begin
         sat_w = 16'sh7fff;
      end else if (nw < -20'sd32768) begin
         sat_w = -16'sh8000;
      end else begin
         sat_w = nw[15:0];
      end
   end

   always_ff @(posedge clock) begin
      s1_ff      <= link_in;
      s2_ff      <= s1_ff;
      s3_ff      <= s3_in;
      s2_w_ff    <= w;
      s2_prod_ff <= prod;
      s3_w_ff    <= s2_w_ff;
      s3_p_ff    <= p_in;
      if (reset) begin
         s1_ff.valid <= 1'b0;
         s2_ff.valid <= 1'b0;
         s3_ff.valid <= 1'b0;
      end
   end

   assign link_out = s3_ff;

endmodule

// ===== rtl/som_bmu_search_and_update_top.sv =====
// ----------------------------------------------------------------------------
// som_bmu_search_and_update_top
// Kohonen map trainer: host weight access, best-matching node search and
// neighborhood update over a row of per-element cells.
// ----------------------------------------------------------------------------
// Weight write, non-final sample, unused code: no response.
// Weight read: the request moves to the read state, which loads the response once it is free.
// Final sample: a search over all h*w nodes and a drain of the cell chain, then per node
//   a distance and check step, plus a 5-step divider and an issue inside the neighborhood,
//   then a drain and the response load; one request at a time, input stalled meanwhile.
// Reset clears control and the size registers (16); weights and samples are not cleared.
module som_bmu_search_and_update_top #(
   parameter int MAX_COLUMNS = som_bmu_pkg::MAX_COLUMNS_DEF,
   parameter int MAX_ROWS    = som_bmu_pkg::MAX_ROWS_DEF,
   parameter int MAX_DIM     = som_bmu_pkg::MAX_DIM_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  som_bmu_pkg::req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output som_bmu_pkg::rsp_type rsp_data,
   input  logic                 csr_psel,
   input  logic                 csr_penable,
   input  logic                 csr_pwrite,
   input  logic [3:0]           csr_paddr,
   input  logic [31:0]          csr_pwdata,
   output logic [31:0]          csr_prdata,
   output logic                 csr_pready
);

   localparam int CW    = som_bmu_pkg::CRD_W;
   localparam int DW    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
   localparam int DRAIN = 3 * MAX_DIM + 1;
   localparam int DRW   = $clog2(DRAIN + 1);

   typedef enum logic [9:0] {
      ST_IDLE   = 10'b0000000001,
      ST_READ   = 10'b0000000010,
      ST_SEARCH = 10'b0000000100,
      ST_SDRAIN = 10'b0000001000,
      ST_DIST   = 10'b0000010000,
      ST_CHECK  = 10'b0000100000,
      ST_DIV    = 10'b0001000000,
      ST_ISSUE  = 10'b0010000000,
      ST_UDRAIN = 10'b0100000000,
      ST_DONE   = 10'b1000000000
   } state_type;

   state_type state_ff, state_in;

   logic [som_bmu_pkg::CFG_W-1:0] map_width_ff, map_height_ff, vector_length_ff;
   logic [6:0]                    w_use, h_use, n_use;
   logic                          csr_wr;

   logic                          req_acc;
   logic                          addr_ok;
   som_bmu_pkg::host_type         host;
   som_bmu_pkg::link_type         chain [MAX_DIM+1];
   logic signed [15:0]            cell_rd [MAX_DIM];
   som_bmu_pkg::link_type         link0;
   som_bmu_pkg::link_type         tail;

   logic [CW-1:0]                 row_ff, row_in, col_ff, col_in;
   logic [CW-1:0]                 br_ff, bc_ff;
   logic [som_bmu_pkg::SUM_W-1:0] best_ff;
   logic                          have_ff;
   logic [15:0]                   lr_ff;
   logic [23:0]                   nsq_ff;
   logic                          rd_ok_ff;
   logic [DW-1:0]                 rd_dim_ff;
   logic [DRW-1:0]                drain_ff, drain_in;
   logic [12:0]                   dsq_ff;
   logic [23:0]                   rem_ff, rem_in;
   logic [4:0]                    q_ff, q_in;
   logic [2:0]                    step_ff, step_in;
   logic                          last_node;
   logic signed [CW:0]            dr, dc;
   logic signed [12:0]            dr_sq, dc_sq;
   logic [20:0]                   scaled;
   logic [24:0]                   rem2;
   logic                          rsp_free;
   logic                          rsp_valid_ff;
   som_bmu_pkg::rsp_type          rsp_ff;

   function automatic logic [6:0] clamp_size(input logic [4:0] v, input int maxv);
      logic [6:0] r;
      begin
         r = {2'b00, v};
         if (v == 5'd0) begin
            r = 7'd1;
         end else if (int'(v) > maxv) begin
            r = 7'(maxv);
         end
         return r;
      end
   endfunction

   // configuration
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         map_width_ff     <= 5'd16;
         map_height_ff    <= 5'd16;
         vector_length_ff <= 5'd16;
      end else if (csr_wr) begin
         unique case (csr_paddr[3:2])
            som_bmu_pkg::REG_MAP_WIDTH:     map_width_ff     <= csr_pwdata[4:0];
            som_bmu_pkg::REG_MAP_HEIGHT:    map_height_ff    <= csr_pwdata[4:0];
            som_bmu_pkg::REG_VECTOR_LENGTH: vector_length_ff <= csr_pwdata[4:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[3:2])
         som_bmu_pkg::REG_MAP_WIDTH:     csr_prdata = {27'd0, map_width_ff};
         som_bmu_pkg::REG_MAP_HEIGHT:    csr_prdata = {27'd0, map_height_ff};
         som_bmu_pkg::REG_VECTOR_LENGTH: csr_prdata = {27'd0, vector_length_ff};
         default:                        csr_prdata = 32'd0;
      endcase
   end

   assign w_use = clamp_size(map_width_ff, MAX_COLUMNS);
   assign h_use = clamp_size(map_height_ff, MAX_ROWS);
   assign n_use = clamp_size(vector_length_ff, MAX_DIM);

   // request side
   assign req_stall = (state_ff != ST_IDLE);
   assign req_acc   = req_valid && !req_stall;
   assign addr_ok   = (int'(req_data.node_index[7:4]) < MAX_ROWS)
                   && (int'(req_data.node_index[3:0]) < MAX_COLUMNS)
                   && (int'(req_data.dim_index) < MAX_DIM);

   always_comb begin
      host.rd     = req_acc && (req_data.func == som_bmu_pkg::FUNC_READ) && addr_ok;
      host.wr     = req_acc && (req_data.func == som_bmu_pkg::FUNC_WRITE) && addr_ok;
      host.sample = req_acc && (req_data.func == som_bmu_pkg::FUNC_TRAIN)
                 && (int'(req_data.dim_index) < MAX_DIM);
      host.dim    = req_data.dim_index;
      host.row    = req_data.node_index[7:4];
      host.col    = req_data.node_index[3:0];
      host.value  = req_data.value;
   end

   always_comb begin
      link0       = '0;
      link0.row   = row_ff;
      link0.col   = col_ff;
      link0.valid = (state_ff == ST_SEARCH) || (state_ff == ST_ISSUE);
      link0.train = (state_ff == ST_ISSUE);
      link0.infl  = som_bmu_pkg::INFL_TABLE[q_ff];
   end

   assign chain[0] = link0;

   for (genvar i = 0; i < MAX_DIM; i++) begin : g_cell
      som_bmu_cell #(
         .MAX_ROWS   (MAX_ROWS),
         .MAX_COLUMNS(MAX_COLUMNS),
         .IDX        (i)
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .link_in (chain[i]),
         .host    (host),
         .active  (i < int'(n_use)),
         .gain    (lr_ff),
         .link_out(chain[i+1]),
         .rd_value(cell_rd[i])
      );
   end

   assign tail = chain[MAX_DIM];

   // node walk and neighborhood arithmetic
   assign last_node = (row_ff == CW'(h_use - 7'd1)) && (col_ff == CW'(w_use - 7'd1));
   assign dr        = signed'({1'b0, row_ff}) - signed'({1'b0, br_ff});
   assign dc        = signed'({1'b0, col_ff}) - signed'({1'b0, bc_ff});
   assign dr_sq     = 13'(dr) * 13'(dr);
   assign dc_sq     = 13'(dc) * 13'(dc);
   assign scaled    = {dsq_ff, 8'd0};
   assign rem2      = {rem_ff, 1'b0};
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      if (col_ff == CW'(w_use - 7'd1)) begin
         col_in = '0;
         row_in = row_ff + 1'b1;
      end else begin
         col_in = col_ff + 1'b1;
         row_in = row_ff;
      end
   end

   always_comb begin
      state_in = state_ff;
      drain_in = drain_ff + 1'b1;
      rem_in   = rem_ff;
      q_in     = q_ff;
      step_in  = step_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc && req_data.func == som_bmu_pkg::FUNC_READ) begin
               state_in = ST_READ;
            end else if (req_acc && req_data.func == som_bmu_pkg::FUNC_TRAIN
                         && req_data.last_element) begin
               state_in = ST_SEARCH;
            end
         end
         ST_READ: begin
            if (rsp_free) state_in = ST_IDLE;
         end
         ST_SEARCH: begin
            drain_in = '0;
            if (last_node) state_in = ST_SDRAIN;
         end
         ST_SDRAIN: begin
            if (drain_ff == DRW'(DRAIN - 1)) state_in = ST_DIST;
         end
         ST_DIST: begin
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            rem_in  = {3'd0, scaled};
            q_in    = '0;
            step_in = '0;
            drain_in = '0;
            if ({3'd0, scaled} < nsq_ff) begin
               state_in = ST_DIV;
            end else if (last_node) begin
               state_in = ST_UDRAIN;
            end else begin
               state_in = ST_DIST;
            end
         end
         ST_DIV: begin
            step_in = step_ff + 1'b1;
            if (rem2 >= {1'b0, nsq_ff}) begin
               rem_in = 24'(rem2 - {1'b0, nsq_ff});
               q_in   = {q_ff[3:0], 1'b1};
            end else begin
               rem_in = rem2[23:0];
               q_in   = {q_ff[3:0], 1'b0};
            end
            if (step_ff == 3'd4) state_in = ST_ISSUE;
         end
         ST_ISSUE: begin
            drain_in = '0;
            state_in = last_node ? ST_UDRAIN : ST_DIST;
         end
         ST_UDRAIN: begin
            if (drain_ff == DRW'(DRAIN - 1)) state_in = ST_DONE;
         end
         ST_DONE: begin
            if (rsp_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      drain_ff <= drain_in;
      rem_ff   <= rem_in;
      q_ff     <= q_in;
      step_ff  <= step_in;
      dsq_ff   <= dr_sq + dc_sq;
      if (state_ff == ST_IDLE && req_acc) begin
         rd_ok_ff  <= addr_ok;
         rd_dim_ff <= DW'(req_data.dim_index);
         lr_ff     <= req_data.gain;
         nsq_ff    <= req_data.neighborhood_sq;
      end
      if (state_ff == ST_IDLE || state_ff == ST_SDRAIN) begin
         row_ff <= '0;
         col_ff <= '0;
      end else if (state_ff == ST_SEARCH || state_ff == ST_ISSUE
                   || (state_ff == ST_CHECK && state_in == ST_DIST)) begin
         row_ff <= row_in;
         col_ff <= col_in;
      end
      if (tail.valid && !tail.train && (!have_ff || tail.sum < best_ff)) begin
         best_ff <= tail.sum;
         br_ff   <= tail.row;
         bc_ff   <= tail.col;
      end
      if (reset) begin
         state_ff <= ST_IDLE;
         have_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_IDLE) begin
            have_ff <= 1'b0;
         end else if (tail.valid && !tail.train) begin
            have_ff <= 1'b1;
         end
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (state_ff == ST_READ && rsp_free) begin
         rsp_ff <= {(rd_ok_ff ? cell_rd[rd_dim_ff] : 16'sd0), 44'd0};
      end else if (state_ff == ST_DONE && rsp_free) begin
         rsp_ff.read_value         <= 16'sd0;
         rsp_ff.winner_column      <= bc_ff[3:0];
         rsp_ff.winner_row         <= br_ff[3:0];
         rsp_ff.winner_distance_sq <= best_ff[35:0];
      end
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if ((state_ff == ST_READ || state_ff == ST_DONE) && rsp_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_READ || state_ff == ST_DONE))
      else $error("response raised outside read or done");

   a_search_only: assert property (@(posedge clock) disable iff (reset)
      (tail.valid && (state_ff == ST_SEARCH || state_ff == ST_SDRAIN)) |-> !tail.train)
      else $error("update node left the chain during search");

   a_winner_found: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIST) |-> have_ff)
      else $error("update started without a winner");

   a_div_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (rem_ff < nsq_ff))
      else $error("divider remainder out of range");

endmodule
